// ===== hw/rtl/clp_pkg.sv =====
// Shared types and constants for the CIDR line parser.
`default_nettype none

package clp_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_line;
    } clp_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] prefix_address;
        logic [5:0]  prefix_length;
    } clp_out_t;

    typedef enum logic [2:0] {
        PH_LEAD      = 3'd0,
        PH_ADDR      = 3'd1,
        PH_LEN       = 3'd2,
        PH_TRAIL     = 3'd3,
        PH_CMT_EMPTY = 3'd4,
        PH_CMT_DONE  = 3'd5,
        PH_ERROR     = 3'd6
    } clp_phase_t;

    typedef struct packed {
        clp_phase_t  phase;
        logic [7:0]  octet_value;
        logic [1:0]  digit_count;
        logic [2:0]  octet_count;
        logic [31:0] address;
        logic [5:0]  length;
    } clp_state_t;

    localparam clp_state_t STATE_RESET = '{
        phase:       PH_LEAD,
        octet_value: 8'd0,
        digit_count: 2'd0,
        octet_count: 3'd0,
        address:     32'd0,
        length:      6'd0
    };

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_ERROR = 2'd2;

    localparam logic [7:0] CHAR_SPACE   = 8'd32;
    localparam logic [7:0] CHAR_TAB     = 8'd9;
    localparam logic [7:0] CHAR_HASH    = 8'd35;
    localparam logic [7:0] CHAR_NUL     = 8'd0;
    localparam logic [7:0] CHAR_DOT     = 8'd46;
    localparam logic [7:0] CHAR_SLASH   = 8'd47;
    localparam logic [7:0] CHAR_ZERO    = 8'd48;
    localparam logic [7:0] CHAR_NINE    = 8'd57;

    localparam logic [11:0] OCTET_MAX   = 12'd255;
    localparam logic [8:0]  LENGTH_MAX  = 9'd32;
    localparam logic [5:0]  FULL_LENGTH = 6'd32;
    localparam logic [2:0]  ALL_OCTETS  = 3'd4;

endpackage

`default_nettype wire

// ===== hw/rtl/clp_step.sv =====
// Next-state and result logic for one character or line end.
`default_nettype none

module clp_step (
    input  wire clp_pkg::clp_state_t state,
    input  wire clp_pkg::clp_in_t    item,
    output clp_pkg::clp_state_t      state_next,
    output clp_pkg::clp_out_t        result
);

    logic [7:0]  c;
    logic        is_blank;
    logic        is_cmt;
    logic        is_digit;
    clp_pkg::clp_phase_t eff_phase;
    logic        close_ok;
    logic [31:0] shifted;
    logic [31:0] filled;
    logic [31:0] mask;
    logic        fin_ok;
    logic [31:0] fin_addr;
    logic [5:0]  fin_len;
    logic [11:0] oct_sum;
    logic [8:0]  len_sum;

    assign c        = item.char_code;
    assign is_blank = (c == clp_pkg::CHAR_SPACE) || (c == clp_pkg::CHAR_TAB);
    assign is_cmt   = (c == clp_pkg::CHAR_HASH) || (c == clp_pkg::CHAR_NUL);
    assign is_digit = (c >= clp_pkg::CHAR_ZERO) && (c <= clp_pkg::CHAR_NINE);

    // a first non-blank, non-comment character starts the address at once
    assign eff_phase = (state.phase == clp_pkg::PH_LEAD && !is_blank && !is_cmt)
                     ? clp_pkg::PH_ADDR : state.phase;

    assign close_ok = (state.digit_count != 2'd0) && (state.octet_count < clp_pkg::ALL_OCTETS);
    assign shifted  = {state.address[23:0], state.octet_value};
    assign oct_sum  = ({4'd0, state.octet_value} * 12'd10) + {8'd0, c[3:0]};
    assign len_sum  = ({3'd0, state.length} * 9'd10) + {5'd0, c[3:0]};

    // zero-fill the missing octets of a short prefix
    always_comb
    begin
        unique case (state.octet_count)
            3'd1:    filled = {state.address[7:0], 24'd0};
            3'd2:    filled = {state.address[15:0], 16'd0};
            3'd3:    filled = {state.address[23:0], 8'd0};
            default: filled = state.address;
        endcase
    end

    assign mask = ~(32'hFFFF_FFFF >> state.length);

    always_comb
    begin
        if (state.phase == clp_pkg::PH_ADDR)
        begin
            fin_ok   = close_ok && (state.octet_count == 3'd3);
            fin_addr = shifted;
            fin_len  = clp_pkg::FULL_LENGTH;
        end
        else
        begin
            fin_ok   = (state.digit_count != 2'd0)
                    && (state.length <= {state.octet_count, 3'b000});
            fin_addr = filled & mask;
            fin_len  = state.length;
        end
    end

    always_comb
    begin
        state_next = state;
        result     = '{status: clp_pkg::STATUS_ERROR, prefix_address: 32'd0,
                       prefix_length: 6'd0};

        if (item.end_of_line)
        begin
            state_next = clp_pkg::STATE_RESET;
            unique case (state.phase)
                clp_pkg::PH_LEAD, clp_pkg::PH_CMT_EMPTY:
                    result.status = clp_pkg::STATUS_EMPTY;
                clp_pkg::PH_ADDR, clp_pkg::PH_LEN:
                begin
                    if (fin_ok)
                    begin
                        result.status         = clp_pkg::STATUS_OK;
                        result.prefix_address = fin_addr;
                        result.prefix_length  = fin_len;
                    end
                end
                clp_pkg::PH_TRAIL, clp_pkg::PH_CMT_DONE:
                begin
                    result.status         = clp_pkg::STATUS_OK;
                    result.prefix_address = state.address;
                    result.prefix_length  = state.length;
                end
                default:
                    result.status = clp_pkg::STATUS_ERROR;
            endcase
        end
        else
        begin
            unique case (eff_phase)
                clp_pkg::PH_LEAD:
                begin
                    if (is_cmt)
                        state_next.phase = clp_pkg::PH_CMT_EMPTY;
                end
                clp_pkg::PH_ADDR, clp_pkg::PH_LEN:
                begin
                    state_next.phase = eff_phase;
                    if (is_digit)
                    begin
                        if (eff_phase == clp_pkg::PH_ADDR)
                        begin
                            if (oct_sum > clp_pkg::OCTET_MAX || state.digit_count == 2'd3)
                                state_next.phase = clp_pkg::PH_ERROR;
                            else
                            begin
                                state_next.octet_value = oct_sum[7:0];
                                state_next.digit_count = state.digit_count + 2'd1;
                            end
                        end
                        else
                        begin
                            if (len_sum > clp_pkg::LENGTH_MAX || state.digit_count >= 2'd2)
                                state_next.phase = clp_pkg::PH_ERROR;
                            else
                            begin
                                state_next.length      = len_sum[5:0];
                                state_next.digit_count = state.digit_count + 2'd1;
                            end
                        end
                    end
                    else if (is_blank || is_cmt)
                    begin
                        if (fin_ok)
                        begin
                            state_next.address = fin_addr;
                            state_next.length  = fin_len;
                            state_next.phase   = is_blank ? clp_pkg::PH_TRAIL
                                                          : clp_pkg::PH_CMT_DONE;
                        end
                        else
                            state_next.phase = clp_pkg::PH_ERROR;
                    end
                    else if (eff_phase == clp_pkg::PH_ADDR
                             && (c == clp_pkg::CHAR_DOT || c == clp_pkg::CHAR_SLASH))
                    begin
                        if (close_ok)
                        begin
                            state_next.address     = shifted;
                            state_next.octet_count = state.octet_count + 3'd1;
                            state_next.octet_value = 8'd0;
                            state_next.digit_count = 2'd0;
                            if (c == clp_pkg::CHAR_SLASH)
                            begin
                                state_next.phase  = clp_pkg::PH_LEN;
                                state_next.length = 6'd0;
                            end
                        end
                        else
                            state_next.phase = clp_pkg::PH_ERROR;
                    end
                    else
                        state_next.phase = clp_pkg::PH_ERROR;
                end
                clp_pkg::PH_TRAIL:
                begin
                    if (is_cmt)
                        state_next.phase = clp_pkg::PH_CMT_DONE;
                    else if (!is_blank)
                        state_next.phase = clp_pkg::PH_ERROR;
                end
                clp_pkg::PH_CMT_EMPTY, clp_pkg::PH_CMT_DONE:
                    state_next.phase = state.phase;
                default:
                    state_next.phase = clp_pkg::PH_ERROR;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cidr_line_parser.sv =====
// Top level of the streaming IPv4 CIDR line parser.
//
//  channel  | direction | payload          | transfer
//  ---------+-----------+------------------+--------------------------------
//  char     | in        | clp_in_t         | char_valid && !char_stall
//  result   | out       | clp_out_t        | result_valid && !result_stall
//
// One character or line end is taken every cycle unless a waiting line end
// stalls the input; the parser step is a single pass of logic between the
// input register and the parser state/result regs. A line end's result
// passes through the input register, then the result register, before it
// can transfer out. Reset returns the parser to the leading-blank phase and
// empties both registers. Only a line end waits: it holds the input register,
// and the items behind it, while an earlier result is still held and stalled.
`default_nettype none

module cidr_line_parser (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  char_valid,
    output logic                 char_stall,
    input  wire clp_pkg::clp_in_t char_item,
    output logic                 result_valid,
    input  wire                  result_stall,
    output clp_pkg::clp_out_t    result_item
);

    logic                in_valid_reg;
    clp_pkg::clp_in_t    in_item_reg;
    clp_pkg::clp_state_t state_reg;
    clp_pkg::clp_state_t state_next;
    logic                res_valid_reg;
    clp_pkg::clp_out_t   res_item_reg;
    clp_pkg::clp_out_t   res_next;
    logic                advance;
    logic                take;

    clp_step u_step (
        .state      (state_reg),
        .item       (in_item_reg),
        .state_next (state_next),
        .result     (res_next)
    );

    // advance the held item unless it is a line end and the result slot is full and stalled
    assign advance = in_valid_reg
                  && (!in_item_reg.end_of_line || !res_valid_reg || !result_stall);
    assign char_stall = in_valid_reg && !advance;
    assign take       = char_valid && !char_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg     <= clp_pkg::STATE_RESET;
        end
        else
        begin
            if (take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                state_reg <= state_next;

            // load on a line end, drop once the result transfer completes
            if (advance && in_item_reg.end_of_line)
                res_valid_reg <= 1'b1;
            else if (!result_stall)
                res_valid_reg <= 1'b0;
        end
    end

    // payload registers: hold while stalled
    always_ff @(posedge clk)
    begin
        if (take)
            in_item_reg <= char_item;
        if (advance && in_item_reg.end_of_line)
            res_item_reg <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign result_item  = res_item_reg;

endmodule

`default_nettype wire
